// File: design/sha256_hash_engine_assert.svh
// Assertion macros for the hash engine checker.
// Both expect signals named clock and reset in the enclosing scope.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SHA256_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define SHA256_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_DONE
   } state_type;

   localparam logic [1:0] ACT_ABSORB        = 2'd0;
   localparam logic [1:0] ACT_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] ACT_FINISH        = 2'd2;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_BYTE  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   localparam logic [31:0] INIT_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// File: design/sha256_hash_engine.sv
`timescale 1ns / 1ps
// SHA-256 engine fed one message byte per request.
// Request channel (req_): req_action selects absorb, absorb-and-finish or
// finish-only; req_data_byte carries the byte. A request is taken on a rising
// edge with req_valid high and req_stall low. req_stall is high whenever the
// sequencer is busy, so requests are taken one at a time.
// Response channel (rsp_): the 256-bit digest as four 64-bit words, held in an
// output register until taken (rsp_valid high, rsp_stall low).
// After a plain absorb the engine is free for the next byte; the 64th byte of a
// block starts a compression (one round per cycle on a single round unit),
// after which the result is folded into the chaining words.
// Finish: padding and length bytes are pushed one per cycle through the same
// byte path, pausing while a filled block is compressed; this gives one or two
// compressions before the digest is loaded and rsp_valid rises.
// A waiting digest does not block new bytes; only the next finish waits in
// its last step until the previous digest has been taken.
// Reset (synchronous, active high) loads the initial hash words, clears the
// byte and length counters and drops rsp_valid. No clearing pass is needed.
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_0,
   output logic [63:0] rsp_digest_1,
   output logic [63:0] rsp_digest_2,
   output logic [63:0] rsp_digest_3
);

   sha256_pkg::state_type state_ff, state_in;

   // Chaining words and working variables a..h (index 0 is a)
   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic [31:0]  vars_ff  [8];
   logic [31:0]  vars_in  [8];

   // 64-byte block as a shift line; during rounds it is the 16-word schedule
   logic [511:0] block_ff, block_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  msg_ff, msg_in;
   logic [63:0]  len_ff, len_in;      // bit length, sent most significant byte first
   logic [5:0]   rnd_ff, rnd_in;

   // Finish progress: padding requested, 0x80 sent, length bytes under way
   logic         pad_ff, pad_in;
   logic         mark_ff, mark_in;
   logic         tail_ff, tail_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  digest_ff [4];
   logic [63:0]  digest_in [4];

   logic         req_fire;
   logic         takes_byte;
   logic         finish_req;
   logic         push_en;
   logic [7:0]   push_byte;
   logic         block_full;
   logic         rsp_free;
   logic [63:0]  msg_next;

   logic [31:0]  w_cur;
   logic [31:0]  w_new;
   logic [31:0]  t1;
   logic [31:0]  t2;
   logic [31:0]  choose;
   logic [31:0]  major;

   assign req_fire   = req_valid && (state_ff == sha256_pkg::ST_IDLE);
   assign takes_byte = (req_action == sha256_pkg::ACT_ABSORB)
                    || (req_action == sha256_pkg::ACT_ABSORB_FINISH);
   assign finish_req = (req_action != sha256_pkg::ACT_ABSORB);
   assign block_full = push_en && (fill_ff == sha256_pkg::LAST_BYTE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign msg_next   = msg_ff + 64'(takes_byte);

   // Round unit
   assign w_cur  = block_ff[511:480];
   assign choose = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign major  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                 ^ (vars_ff[1] & vars_ff[2]);
   assign t1     = vars_ff[7] + sha256_pkg::big_sigma1(vars_ff[4]) + choose
                 + sha256_pkg::ROUND_K[rnd_ff] + w_cur;
   assign t2     = sha256_pkg::big_sigma0(vars_ff[0]) + major;

   // Schedule: w[t+16] from window words 0, 1, 9 and 14
   assign w_new  = sha256_pkg::small_sigma1(block_ff[63:32]) + block_ff[223:192]
                 + sha256_pkg::small_sigma0(block_ff[479:448]) + w_cur;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (block_full) begin
                  state_in = sha256_pkg::ST_ROUND;
               end else if (finish_req) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_ROUND: begin
            if (rnd_ff == sha256_pkg::LAST_ROUND) begin
               state_in = sha256_pkg::ST_FOLD;
            end
         end
         sha256_pkg::ST_FOLD: begin
            if (tail_ff) begin
               state_in = sha256_pkg::ST_DONE;
            end else if (pad_ff) begin
               state_in = sha256_pkg::ST_PAD;
            end else begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: stall and the byte pushed into the block
   always_comb begin
      req_stall = 1'b1;
      push_en   = 1'b0;
      push_byte = '0;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            push_en   = req_fire && takes_byte;
            push_byte = req_data_byte;
         end
         sha256_pkg::ST_PAD: begin
            push_en = 1'b1;
            if (!mark_ff) begin
               push_byte = sha256_pkg::PAD_MARK;
            end else if (tail_ff || (fill_ff == sha256_pkg::LEN_OFFSET)) begin
               push_byte = len_ff[63:56];
            end else begin
               push_byte = 8'h00;
            end
         end
         sha256_pkg::ST_ROUND,
         sha256_pkg::ST_FOLD,
         sha256_pkg::ST_DONE: begin
            req_stall = 1'b1;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Datapath
   always_comb begin
      chain_in     = chain_ff;
      vars_in      = vars_ff;
      block_in     = block_ff;
      fill_in      = fill_ff;
      msg_in       = msg_ff;
      len_in       = len_ff;
      rnd_in       = rnd_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      tail_in      = tail_ff;
      digest_in    = digest_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (push_en) begin
         block_in = {block_ff[503:0], push_byte};
         fill_in  = fill_ff + 6'd1;
      end
      if (block_full) begin
         vars_in = chain_ff;
         rnd_in  = '0;
      end

      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_fire) begin
               msg_in = msg_next;
               if (finish_req) begin
                  pad_in = 1'b1;
                  len_in = {msg_next[60:0], 3'b000};
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            if (!mark_ff) begin
               mark_in = 1'b1;
            end else if (tail_ff || (fill_ff == sha256_pkg::LEN_OFFSET)) begin
               tail_in = 1'b1;
               len_in  = {len_ff[55:0], 8'h00};
            end
         end
         sha256_pkg::ST_ROUND: begin
            vars_in[0] = t1 + t2;
            vars_in[1] = vars_ff[0];
            vars_in[2] = vars_ff[1];
            vars_in[3] = vars_ff[2];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[5] = vars_ff[4];
            vars_in[6] = vars_ff[5];
            vars_in[7] = vars_ff[6];
            block_in   = {block_ff[479:0], w_new};
            rnd_in     = rnd_ff + 6'd1;
         end
         sha256_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
         end
         sha256_pkg::ST_DONE: begin
            if (rsp_free) begin
               for (int i = 0; i < 4; i++) begin
                  digest_in[i] = {chain_ff[2 * i], chain_ff[2 * i + 1]};
               end
               rsp_valid_in = 1'b1;
               chain_in     = sha256_pkg::INIT_WORDS;
               msg_in       = '0;
               pad_in       = 1'b0;
               mark_in      = 1'b0;
               tail_in      = 1'b0;
            end
         end
         default: begin
            rnd_in = rnd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha256_pkg::ST_IDLE;
         chain_ff     <= sha256_pkg::INIT_WORDS;
         fill_ff      <= '0;
         msg_ff       <= '0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         msg_ff       <= msg_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      vars_ff   <= vars_in;
      block_ff  <= block_in;
      len_ff    <= len_in;
      rnd_ff    <= rnd_in;
      digest_ff <= digest_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digest_0 = digest_ff[0];
   assign rsp_digest_1 = digest_ff[1];
   assign rsp_digest_2 = digest_ff[2];
   assign rsp_digest_3 = digest_ff[3];

endmodule

// File: design/sha256_checker.sv
`timescale 1ns / 1ps
`include "sha256_hash_engine_assert.svh"

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_digest_0,
   input logic [63:0] rsp_digest_1,
   input logic [63:0] rsp_digest_2,
   input logic [63:0] rsp_digest_3
);

   // A stalled digest stays put
   `SHA256_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest_0) && $stable(rsp_digest_1) && $stable(rsp_digest_2) && $stable(rsp_digest_3), "digest changed while stalled")

   // Any finishing request sends the engine busy, into padding or first into a compression
   `SHA256_ASSERT_NEXT(a_finish_busy, req_valid && !req_stall && req_action != sha256_pkg::ACT_ABSORB, req_stall, "engine free right after a finish request")

   // A digest is only loaded from the busy final step
   `SHA256_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "digest appeared while engine was free")

endmodule

bind sha256_hash_engine sha256_checker u_sha256_checker (.*);
